// ----- hw/rtl/hht_pkg.sv -----
// ============================================================================
// hht_pkg: shared types and constants for the heading history tracker
// Field widths, register indexes, operation codes and fixed limits used by
// the tracker's storage, integration and scan logic.
// ============================================================================
package hht_pkg;

  // Field widths.
  localparam int TIME_W   = 64;
  localparam int YAW_W    = 32;
  localparam int RATE_W   = 32;
  localparam int LIMIT_W  = 12;
  localparam int MAXGAP_W = 32;

  // One stored sample: yaw above time.
  localparam int ENTRY_W = TIME_W + YAW_W;

  // A valid integration step is below 10 s, so the gap fits 24 bits.
  localparam int STEP_W = 24;
  localparam logic [STEP_W-1:0] MAX_STEP_US = 24'd10_000_000;

  // Register defaults and limits.
  localparam int                    DEFAULT_DEPTH  = 2048;
  localparam logic [MAXGAP_W-1:0]   DEFAULT_GAP_US = 32'd500_000;
  localparam logic [LIMIT_W-1:0]    MIN_LIMIT      = 12'd10;
  localparam logic [LIMIT_W-1:0]    RESET_LIMIT    = 12'd2000;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register index, taken from the word address bit.
  typedef enum logic {
    CFG_LIMIT = 1'b0,
    CFG_GAP   = 1'b1
  } cfg_idx_t;

  // Operation codes carried in the input tuser.
  typedef enum logic {
    OP_ODOM  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // Status and best match from the scan unit.
  typedef struct packed {
    logic              busy;
    logic              have;
    logic [TIME_W-1:0] gap;
    logic [YAW_W-1:0]  yaw;
  } scan_res_t;

endpackage

// ----- hw/rtl/hht_ram.sv -----
// ============================================================================
// hht_ram: sample history memory
// Single write port, single read port with a registered read.
// Each entry holds one (time, yaw) sample.
// ============================================================================
module hht_ram #(
  parameter int DEPTH = hht_pkg::DEFAULT_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [hht_pkg::ENTRY_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [hht_pkg::ENTRY_W-1:0] rd_data,
  output logic                       rd_valid
);
  import hht_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Read data qualifier.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
  end

endmodule

// ----- hw/rtl/hht_yaw.sv -----
// ============================================================================
// hht_yaw: yaw integrator
// Holds the last event time and heading and advances the heading by
// rate times gap over three pipeline steps for each odometry event with a valid gap.
// ============================================================================
module hht_yaw (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [hht_pkg::TIME_W-1:0]       time_in,
  input  logic signed [hht_pkg::RATE_W-1:0] rate_in,
  output logic                             done,
  output logic [hht_pkg::YAW_W-1:0]        heading
);
  import hht_pkg::*;

  logic [TIME_W-1:0]  t_r;
  logic [RATE_W-1:0]  rate_r;
  logic [TIME_W-1:0]  last_time;
  logic               has_prev;
  logic               v0;
  logic               v1;
  logic               v2;
  logic               ok_r;
  logic               first_r;
  logic [STEP_W-1:0]  gap_r;
  logic [YAW_W-1:0]   prod_r;
  logic [TIME_W:0]    diff;
  logic               gap_ok;

  // Gap from the previous event; the borrow bit flags time going backwards.
  assign diff   = {1'b0, t_r} - {1'b0, last_time};
  assign gap_ok = has_prev && !diff[TIME_W] && (diff[TIME_W-1:0] != '0) &&
                  (diff[TIME_W-1:0] < TIME_W'(MAX_STEP_US));

  // Step control.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0       <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      done     <= 1'b0;
      has_prev <= 1'b0;
      last_time <= '0;
      heading  <= '0;
    end else begin
      v0   <= start;
      v1   <= v0;
      v2   <= v1;
      done <= v2;
      if (v2) begin
        // The first event sets the heading to zero.
        if (first_r) begin
          heading <= '0;
        end else if (ok_r) begin
          heading <= heading + prod_r;
        end
        last_time <= t_r;
        has_prev  <= 1'b1;
      end
    end
  end

  // Operand and product registers.
  always_ff @(posedge clk) begin
    if (start) begin
      t_r    <= time_in;
      rate_r <= rate_in;
    end
    if (v0) begin
      ok_r    <= gap_ok;
      first_r <= !has_prev;
      gap_r   <= diff[STEP_W-1:0];
    end
    if (v1) begin
      // Only the low word matters: the angle wraps modulo one turn.
      prod_r <= YAW_W'(rate_r * {{(RATE_W-STEP_W){1'b0}}, gap_r});
    end
  end

endmodule

// ----- hw/rtl/hht_scan.sv -----
// ============================================================================
// hht_scan: nearest sample search
// Takes stored samples newest first, forms the time distance to the query
// and keeps the closest one; on a tie the earlier seen (newer) sample stays.
// ============================================================================
module hht_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [hht_pkg::TIME_W-1:0]    qtime,
  input  logic                          rd_valid,
  input  logic [hht_pkg::ENTRY_W-1:0]   rd_data,
  output hht_pkg::scan_res_t            res
);
  import hht_pkg::*;

  logic [TIME_W-1:0] q_r;
  logic [TIME_W-1:0] st;
  logic [TIME_W:0]   d_fwd;
  logic [TIME_W-1:0] d_abs;
  logic              s1_v;
  logic [TIME_W-1:0] d_r;
  logic [YAW_W-1:0]  y_r;
  logic              have;
  logic [TIME_W-1:0] best_gap;
  logic [YAW_W-1:0]  near_yaw;

  // Absolute time distance of the sample just read.
  assign st    = rd_data[TIME_W-1:0];
  assign d_fwd = {1'b0, st} - {1'b0, q_r};
  assign d_abs = d_fwd[TIME_W] ? (q_r - st) : d_fwd[TIME_W-1:0];

  // Control: stage valid and best-found flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      have <= 1'b0;
    end else begin
      s1_v <= rd_valid;
      if (start) begin
        have <= 1'b0;
      end else if (s1_v) begin
        have <= 1'b1;
      end
    end
  end

  // Distance stage and best tracking; strict less keeps the newer on a tie.
  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= qtime;
    end
    if (rd_valid) begin
      d_r <= d_abs;
      y_r <= rd_data[ENTRY_W-1:TIME_W];
    end
    if (s1_v && (!have || (d_r < best_gap))) begin
      best_gap <= d_r;
      near_yaw <= y_r;
    end
  end

  assign res.busy = s1_v;
  assign res.have = have;
  assign res.gap  = best_gap;
  assign res.yaw  = near_yaw;

endmodule

// ----- hw/rtl/heading_history_tracker_top.sv -----
// ============================================================================
// heading_history_tracker_top: yaw integrator with a time-indexed history
// Integrates heading from odometry beats into a ring of (time, yaw) samples
// and answers heading queries with the nearest stored sample.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+-----------------------------------
//   s_*      | in  | s_tvalid/tready  | tuser: operation; tdata: timestamp,
//            |     |                  |   fallback_time, angular_rate
//   m_*      | out | m_tvalid/tready  | tuser: found; tdata: yaw
//   APB      | in  | psel/penable     | 0x0 history_limit, 0x4 max_gap_us
//
// An odometry beat passes through the accept, three integrator steps and one
// memory write.
// A query reads one stored sample per cycle through the history memory's single
// read port, newest first, then drains the read and search pipeline.
// Reset clears the ring pointers, the heading and the registers; no memory sweep.
// One item is in work at a time; the output register holds a result while the
// next item is taken, and a query result waits there for m_tready.
// ============================================================================
module heading_history_tracker_top #(
  parameter int HISTORY_DEPTH = hht_pkg::DEFAULT_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hht_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [hht_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [hht_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  // Input stream.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [63:0] timestamp, [127:64] fallback_time, [159:128] angular_rate
  input  logic [159:0]                      s_tdata,
  // [0] operation
  input  logic                              s_tuser,
  // Output stream.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [31:0] yaw
  output logic [31:0]                       m_tdata,
  // [0] found
  output logic                              m_tuser
);
  import hht_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ODO,
    S_SCAN,
    S_DRAIN,
    S_RESULT
  } state_t;

  state_t                 state;
  logic [LIMIT_W-1:0]     hist_limit;
  logic [MAXGAP_W-1:0]    max_gap;
  logic [AW-1:0]          oldest;
  logic [CW-1:0]          count;
  logic [CW-1:0]          remaining;
  logic [AW-1:0]          scan_addr;
  logic [TIME_W-1:0]      u_yaw_time_q;

  logic                   cfg_wr;
  cfg_idx_t               cfg_idx;
  logic [CW-1:0]          eff_lim;
  logic [CW-1:0]          new_lim;
  logic                   accept;
  logic [TIME_W-1:0]      in_time;
  logic [TIME_W-1:0]      fb_time;
  logic [TIME_W-1:0]      t_eff;
  logic signed [RATE_W-1:0] in_rate;
  op_t                    in_op;
  logic                   odo_start;
  logic                   qry_start;
  logic                   yaw_done;
  logic [YAW_W-1:0]       heading;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic                   rd_en;
  logic [ENTRY_W-1:0]     rd_data;
  logic                   rd_valid;
  scan_res_t              scan_res;
  logic [MAXGAP_W-1:0]    gap_limit;
  logic                   hit;
  logic                   res_load;

  // Clamp a limit value to at least the minimum and at most the depth.
  function automatic logic [CW-1:0] eff_limit_of(input logic [LIMIT_W-1:0] v);
    logic [LW-1:0] x;
    x = LW'(v);
    if (x < LW'(MIN_LIMIT)) x = LW'(MIN_LIMIT);
    if (x > LW'(HISTORY_DEPTH)) x = LW'(HISTORY_DEPTH);
    return CW'(x);
  endfunction

  // Ring index wrap for a sum below twice the depth.
  function automatic logic [AW-1:0] wrap_idx(input logic [SW-1:0] x);
    logic [SW-1:0] y;
    y = (x >= SW'(HISTORY_DEPTH)) ? x - SW'(HISTORY_DEPTH) : x;
    return y[AW-1:0];
  endfunction

  // Configuration decode and read-back.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = cfg_idx_t'(paddr[2]);
  assign eff_lim = eff_limit_of(hist_limit);
  assign new_lim = eff_limit_of(pwdata[LIMIT_W-1:0]);

  always_comb begin
    case (cfg_idx)
      CFG_LIMIT: prdata = {{(CFG_DATA_W-LIMIT_W){1'b0}}, hist_limit};
      CFG_GAP:   prdata = max_gap;
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_limit <= RESET_LIMIT;
      max_gap    <= DEFAULT_GAP_US;
    end else if (cfg_wr) begin
      case (cfg_idx)
        CFG_LIMIT: hist_limit <= pwdata[LIMIT_W-1:0];
        CFG_GAP:   max_gap    <= pwdata;
        default:   ;
      endcase
    end
  end

  // Input beat unpacking; a zero timestamp falls back to the fallback_time field.
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign in_op     = op_t'(s_tuser);
  assign in_time   = s_tdata[63:0];
  assign fb_time   = s_tdata[127:64];
  assign in_rate   = s_tdata[159:128];
  assign t_eff     = (in_time == '0) ? fb_time : in_time;
  assign odo_start = accept && (in_op == OP_ODOM);
  assign qry_start = accept && (in_op == OP_QUERY);

  // Yaw integrator.
  hht_yaw u_yaw (
    .clk     (clk),
    .rst     (rst),
    .start   (odo_start),
    .time_in (t_eff),
    .rate_in (in_rate),
    .done    (yaw_done),
    .heading (heading)
  );

  // History memory: append at the ring head, scan from newest down.
  assign wr_en   = (state == S_ODO) && yaw_done;
  assign wr_addr = wrap_idx(SW'(oldest) + SW'(count));
  assign rd_en   = (state == S_SCAN) && (remaining != '0);

  hht_ram #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  ({heading, u_yaw_time_q}),
    .rd_en    (rd_en),
    .rd_addr  (scan_addr),
    .rd_data  (rd_data),
    .rd_valid (rd_valid)
  );

  // Time of the event in work, held for the memory write.
  always_ff @(posedge clk) begin
    if (odo_start) begin
      u_yaw_time_q <= t_eff;
    end
  end

  // Nearest sample search.
  hht_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (qry_start),
    .qtime    (t_eff),
    .rd_valid (rd_valid),
    .rd_data  (rd_data),
    .res      (scan_res)
  );

  // Hit test against the gap limit; a zero limit means the default.
  assign gap_limit = (max_gap == '0) ? DEFAULT_GAP_US : max_gap;
  assign hit = scan_res.have && (scan_res.gap <= {{(TIME_W-MAXGAP_W){1'b0}}, gap_limit});

  // The output register takes a result when it is empty or being drained.
  assign res_load = (state == S_RESULT) && (!m_tvalid || m_tready);

  // Sequencer, ring pointers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      oldest    <= '0;
      count     <= '0;
      remaining <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (res_load) begin
        m_tvalid <= 1'b1;
        m_tuser  <= hit;
        m_tdata  <= hit ? scan_res.yaw : '0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      // Lowering the limit drops the oldest samples at once.
      if (cfg_wr && (cfg_idx == CFG_LIMIT) && (count > new_lim)) begin
        oldest <= wrap_idx(SW'(oldest) + SW'(count - new_lim));
        count  <= new_lim;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_op == OP_QUERY) begin
              scan_addr <= wrap_idx(SW'(oldest) + SW'(count) - SW'(1));
              remaining <= count;
              state     <= S_SCAN;
            end else begin
              state <= S_ODO;
            end
          end
        end
        S_ODO: begin
          if (yaw_done) begin
            // A full ring overwrites its oldest entry.
            if (count < eff_lim) begin
              count <= count + CW'(1);
            end else begin
              oldest <= wrap_idx(SW'(oldest) + SW'(1));
            end
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (remaining == '0) begin
            state <= S_DRAIN;
          end else begin
            scan_addr <= (scan_addr == '0) ? AW'(HISTORY_DEPTH - 1) : scan_addr - AW'(1);
            remaining <= remaining - CW'(1);
          end
        end
        S_DRAIN: begin
          if (!rd_valid && !scan_res.busy) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The ring never holds more samples than the effective limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    count <= eff_lim)
    else $error("sample count exceeds history limit");

  // Appends and scan reads never share a cycle.
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("memory write during scan");

  // A miss always reports a zero heading.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("miss beat with nonzero yaw");

  // A result beat only appears after the result step.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_RESULT))
    else $error("result beat without a finished query");

endmodule

// ----- tb/tb_top.sv -----
// ============================================================================
// tb_top: stream-level testbench for the heading history tracker
// Drives odometry and heading-query beats through the input stream, writes the
// history limit and gap registers between phases, and predicts every query
// answer with an internal yaw integrator and sample ring. Query answers are
// compared field by field, in order, against the predicted queue.
// ============================================================================
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hht_pkg::*;

  localparam int DEPTH = DEFAULT_DEPTH;
  localparam logic [63:0] STEP_LIMIT = {40'd0, MAX_STEP_US};

  // Expected answer of one heading query.
  typedef struct packed {
    logic        found;
    logic [31:0] yaw;
  } heading_result_t;

  // Yaw integrator and sample ring that mirror the block, plus the queue of
  // query answers still owed by it.
  class heading_scoreboard;
    logic [63:0]     ring_time [DEPTH];
    logic [31:0]     ring_yaw  [DEPTH];
    int unsigned     oldest;
    int unsigned     count;
    logic [63:0]     prev_time;
    logic [31:0]     heading;
    bit              started;
    logic [11:0]     limit_reg;
    logic [31:0]     gap_reg;
    heading_result_t pending [$];
    int              errors;

    function void reset_state();
      oldest    = 0;
      count     = 0;
      prev_time = '0;
      heading   = '0;
      started   = 1'b0;
      limit_reg = RESET_LIMIT;
      gap_reg   = DEFAULT_GAP_US;
      pending.delete();
      errors    = 0;
    endfunction

    function int unsigned keep_limit();
      int unsigned lim;
      lim = limit_reg;
      if (lim < MIN_LIMIT) lim = MIN_LIMIT;
      if (lim > DEPTH) lim = DEPTH;
      return lim;
    endfunction

    function logic [31:0] effective_gap();
      return (gap_reg == '0) ? DEFAULT_GAP_US : gap_reg;
    endfunction

    // Drop the oldest samples until the ring fits the limit.
    function void trim_history();
      while (count > keep_limit()) begin
        oldest = (oldest + 1) % DEPTH;
        count--;
      end
    endfunction

    function void write_reg(cfg_idx_t idx, logic [31:0] val);
      case (idx)
        CFG_LIMIT: begin
          limit_reg = val[11:0];
          trim_history();
        end
        CFG_GAP: begin
          gap_reg = val;
        end
        default: ;
      endcase
    endfunction

    // A random time that is live in the ring, for exact-hit queries.
    function logic [63:0] live_time(logic [63:0] dflt);
      int unsigned slot;
      if (count == 0) return dflt;
      slot = (oldest + $urandom_range(0, count - 1)) % DEPTH;
      return ring_time[slot];
    endfunction

    function void note_item(op_t op, logic [63:0] ts, logic [63:0] fb, logic [31:0] rate);
      logic [63:0]     t;
      logic [63:0]     d;
      logic [63:0]     best_gap;
      logic [31:0]     near_yaw;
      logic [63:0]     step;
      bit              have;
      int unsigned     slot;
      heading_result_t res;
      t = (ts == '0) ? fb : ts;
      if (op == OP_ODOM) begin
        if (!started) begin
          heading = '0;
          started = 1'b1;
        end else if (t > prev_time && (t - prev_time) < STEP_LIMIT) begin
          step    = t - prev_time;
          heading = heading + rate * step[31:0];
        end
        prev_time = t;
        // Append, overwriting the oldest slot once the store is full.
        if (count < DEPTH) begin
          slot = (oldest + count) % DEPTH;
          count++;
        end else begin
          slot   = oldest;
          oldest = (oldest + 1) % DEPTH;
        end
        ring_time[slot] = t;
        ring_yaw[slot]  = heading;
        trim_history();
      end else begin
        // Newest first; a tie keeps the newer sample and an exact hit stops.
        have     = 1'b0;
        best_gap = '0;
        near_yaw = '0;
        for (int unsigned k = count; k > 0; k--) begin
          slot = (oldest + k - 1) % DEPTH;
          d = (ring_time[slot] > t) ? ring_time[slot] - t : t - ring_time[slot];
          if (!have || d < best_gap) begin
            have     = 1'b1;
            best_gap = d;
            near_yaw = ring_yaw[slot];
            if (d == '0) break;
          end
        end
        if (have && best_gap <= {32'd0, effective_gap()}) begin
          res.found = 1'b1;
          res.yaw   = near_yaw;
        end else begin
          res.found = 1'b0;
          res.yaw   = '0;
        end
        pending = {pending, res};
      end
    endfunction

    function void check_result(logic found, logic [31:0] yaw);
      heading_result_t exp_res;
      if (pending.size() == 0) begin
        $display("%0t: unexpected answer found=%b yaw=%h", $time, found, yaw);
        errors++;
        return;
      end
      exp_res = pending[0];
      pending.delete(0);
      if (found !== exp_res.found) begin
        $display("%0t: found expected %b got %b", $time, exp_res.found, found);
        errors++;
      end
      if (yaw !== exp_res.yaw) begin
        $display("%0t: yaw expected %h got %h", $time, exp_res.yaw, yaw);
        errors++;
      end
    endfunction
  endclass

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr    = '0;
  logic [CFG_DATA_W-1:0] pwdata   = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [159:0]          s_tdata  = '0;
  logic                  s_tuser  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [31:0]           m_tdata;
  logic                  m_tuser;

  heading_scoreboard sb;
  int                tx_idle_pct = 36;
  int                rx_idle_pct = 63;
  int                hold_req    = 0;
  int                hold_left   = 0;
  logic [63:0]       odom_clock  = '0;

  heading_history_tracker_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  // Receiver: random idling, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Every answer beat is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tuser, m_tdata);
    end
  end

  // Offer one beat with random idling ahead of it; returns at a falling edge.
  task automatic send_item(op_t op, logic [63:0] ts, logic [63:0] fb, logic [31:0] rate);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {rate, fb, ts};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(op, ts, fb, rate);
    @(negedge clk);
  endtask

  // Stop offering, wait for every owed answer, then let a trailing odometry
  // update finish inside the block.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Next odometry time: mostly small forward steps, with repeats, backward
  // steps, steps at and around the 10 s bound, and wild jumps.
  function automatic logic [63:0] next_odom_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62)      odom_clock = odom_clock + $urandom_range(1, 200000);
    else if (r < 70) odom_clock = odom_clock;
    else if (r < 78) odom_clock = odom_clock - $urandom_range(1, 300000);
    else if (r < 84) odom_clock = odom_clock + STEP_LIMIT + $urandom_range(0, 50000000);
    else if (r < 88) odom_clock = odom_clock + STEP_LIMIT;
    else if (r < 92) odom_clock = odom_clock + STEP_LIMIT - 64'd1;
    else if (r < 96) odom_clock = {$urandom, $urandom};
    else             odom_clock = odom_clock + $urandom_range(0, 20);
    return odom_clock;
  endfunction

  // Query time: exact hits, near misses around the gap bound, and far times.
  function automatic logic [63:0] next_query_time();
    int          r;
    logic [63:0] span;
    logic [63:0] off;
    logic [63:0] base;
    r    = $urandom_range(0, 99);
    span = {32'd0, sb.effective_gap()};
    off  = {$urandom, $urandom} % (64'd2 * span + 64'd1);
    base = sb.live_time(odom_clock);
    if (r < 20) return base;
    if (r < 75) return $urandom_range(0, 1) ? base + off : base - off;
    if (r < 88) return odom_clock + $urandom_range(0, 40) - 64'd20;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] next_rate();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom;
    if (r < 8) return $urandom_range(0, 2000) - 1000;
    return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  // Random phase; pause_at names the beat before which the sender waits for
  // every owed answer, or is negative for none.
  task automatic run_random(int n, int odom_pct, int pause_at);
    op_t         op;
    logic [63:0] t;
    logic [63:0] ts;
    logic [63:0] fb;
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) begin
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        @(negedge clk);
      end
      op = ($urandom_range(0, 99) < odom_pct) ? OP_ODOM : OP_QUERY;
      t  = (op == OP_ODOM) ? next_odom_time() : next_query_time();
      fb = {$urandom, $urandom};
      ts = t;
      if ($urandom_range(0, 99) < 8) begin
        ts = '0;
        fb = t;
      end
      send_item(op, ts, fb, next_rate());
    end
  endtask

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    sb = new();
    sb.reset_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty history, first sample from the fallback time, steps at
    // the extremes of rate and gap, backward and repeated times, ties, exact
    // hits, the gap bound, and the ends of the time range.
    send_item(OP_QUERY, 64'd5000, 64'd0, 32'd0);
    send_item(OP_ODOM, 64'd0, 64'd1000, 32'h1234_5678);
    send_item(OP_ODOM, 64'd1100, 64'd0, 32'h7FFF_FFFF);
    send_item(OP_ODOM, 64'd10_001_099, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000);
    send_item(OP_ODOM, 64'd20_001_099, 64'd0, 32'hFFFF_FFFF);
    send_item(OP_ODOM, 64'd1050, 64'd0, 32'd5);
    send_item(OP_ODOM, 64'd1050, 64'd0, 32'd7);
    send_item(OP_ODOM, 64'd1060, 64'd0, 32'd1);
    send_item(OP_QUERY, 64'd1100, 64'd0, 32'hFFFF_FFFF);
    send_item(OP_QUERY, 64'd1055, 64'd0, 32'd0);
    send_item(OP_QUERY, 64'd0, 64'd1060, 32'd0);
    send_item(OP_QUERY, 64'd0, 64'd0, 32'd0);
    send_item(OP_QUERY, 64'd501_060, 64'd0, 32'd0);
    send_item(OP_QUERY, 64'd501_061, 64'd0, 32'd0);
    send_item(OP_ODOM, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 32'h5A5A_A5A5);
    send_item(OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 32'd0);
    send_item(OP_QUERY, 64'h8000_0000_0000_0000, 64'd0, 32'd0);
    send_item(OP_ODOM, 64'd0, 64'd0, 32'd9);
    send_item(OP_ODOM, 64'd1, 64'd0, 32'hFFFF_FFFF);
    send_item(OP_QUERY, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send_item(OP_QUERY, 64'd2, 64'd0, 32'd0);
    odom_clock = 64'd5000;

    // Smallest history; a zero gap register falls back to the default.
    wait_for_results();
    write_reg(CFG_LIMIT, 32'd10);
    write_reg(CFG_GAP, 32'd0);
    run_random(40, 60, -1);

    // Limit below the floor and the tightest gap.
    wait_for_results();
    write_reg(CFG_LIMIT, 32'd0);
    write_reg(CFG_GAP, 32'd1);
    run_random(35, 55, -1);

    // Long receiver hold-off so the block backs up, and a sender pause.
    wait_for_results();
    write_reg(CFG_LIMIT, 32'd16);
    write_reg(CFG_GAP, 32'd2000);
    hold_req = 600;
    run_random(40, 40, 25);

    // Largest register values.
    tx_idle_pct = 63;
    rx_idle_pct = 36;
    wait_for_results();
    write_reg(CFG_LIMIT, 32'd4095);
    write_reg(CFG_GAP, 32'hFFFF_FFFF);
    run_random(40, 70, -1);

    // Shrinking the limit drops the oldest samples while idle.
    wait_for_results();
    write_reg(CFG_LIMIT, 32'd11);
    run_random(35, 50, -1);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    wait_for_results();
    write_reg(CFG_LIMIT, 32'd2048);
    write_reg(CFG_GAP, 32'd500_000);
    run_random(40, 60, -1);

    wait_for_results();
    write_reg(CFG_LIMIT, 32'd9);
    write_reg(CFG_GAP, 32'd1000);
    run_random(40, 55, -1);

    // Drain, then leave room for any stray answer to show up.
    wait_for_results();
    repeat (2100) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
